[src/assert_macros.svh]
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication, disabled while reset is applied.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is applied.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[src/pnpb_pkg.sv]
package pnpb_pkg;

	localparam int RING_COUNT_DEF   = 16;
	localparam int SECTOR_COUNT_DEF = 90;
	localparam int COORD_BITS_DEF   = 18;

	localparam int CORDIC_STEPS = 28;
	localparam int ANG_BITS     = 34;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	function automatic logic signed [ANG_BITS-1:0] atan_val(input logic [4:0] i);
		logic signed [ANG_BITS-1:0] r;
		begin
			case (i)
				5'd0:  r = 34'sd536870912;
				5'd1:  r = 34'sd316933405;
				5'd2:  r = 34'sd167458907;
				5'd3:  r = 34'sd85004756;
				5'd4:  r = 34'sd42667331;
				5'd5:  r = 34'sd21354465;
				5'd6:  r = 34'sd10680350;
				5'd7:  r = 34'sd5340245;
				5'd8:  r = 34'sd2670163;
				5'd9:  r = 34'sd1335086;
				5'd10: r = 34'sd667544;
				5'd11: r = 34'sd333772;
				5'd12: r = 34'sd166886;
				5'd13: r = 34'sd83443;
				5'd14: r = 34'sd41721;
				5'd15: r = 34'sd20860;
				5'd16: r = 34'sd10430;
				5'd17: r = 34'sd5215;
				5'd18: r = 34'sd2607;
				5'd19: r = 34'sd1303;
				5'd20: r = 34'sd651;
				5'd21: r = 34'sd325;
				5'd22: r = 34'sd162;
				5'd23: r = 34'sd81;
				5'd24: r = 34'sd40;
				5'd25: r = 34'sd20;
				5'd26: r = 34'sd10;
				5'd27: r = 34'sd5;
				default: r = '0;
			endcase
			return r;
		end
	endfunction

endpackage

[src/pnpb_front.sv]
// Front end: takes items, forms deltas against the origin and resolves the
// sector of an insert with an iterative CORDIC (one micro-rotation a cycle).
module pnpb_front #(
	parameter int RING_COUNT   = pnpb_pkg::RING_COUNT_DEF,
	parameter int SECTOR_COUNT = pnpb_pkg::SECTOR_COUNT_DEF,
	parameter int COORD_BITS   = pnpb_pkg::COORD_BITS_DEF,
	parameter int RB           = 4,
	parameter int SB           = 7,
	parameter int CW           = 18
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   op,
	input  logic [RB-1:0]                ring,
	input  logic [SB-1:0]                sector,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] py,
	input  logic signed [COORD_BITS-1:0] pz,
	input  logic signed [COORD_BITS-1:0] org_x,
	input  logic signed [COORD_BITS-1:0] org_y,
	output logic                         q_valid,
	input  logic                         q_ready,
	output logic [1:0]                   q_op,
	output logic                         q_hit,
	output logic [CW-1:0]                q_cell,
	output logic signed [COORD_BITS-1:0] q_x,
	output logic signed [COORD_BITS-1:0] q_y,
	output logic signed [COORD_BITS-1:0] q_z
);
	import pnpb_pkg::*;

	localparam int DB = COORD_BITS + 1;
	localparam int XB = DB + 14;
	localparam int SIB = $clog2(SECTOR_COUNT);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_ROT  = 3'b010,
		ST_OUT  = 3'b100
	} st_t;

	st_t st_q;
	logic [1:0] op_q;
	logic [RB-1:0] ring_q;
	logic signed [COORD_BITS-1:0] x_q, y_q, z_q;
	logic signed [XB-1:0] cx_q, cy_q;
	logic signed [ANG_BITS-1:0] ang_q;
	logic [4:0] it_q;
	logic hit_q;
	logic [CW-1:0] cell_q;

	logic signed [DB-1:0] dx, dy;
	logic signed [XB-1:0] xs, ys;
	logic signed [ANG_BITS:0] off;
	logic [ANG_BITS+11:0] prod;
	logic [SIB-1:0] sidx;
	logic [CW-1:0] cell_sec;

	assign dx = DB'(px) - DB'(org_x);
	assign dy = DB'(py) - DB'(org_y);
	assign xs = cx_q >>> it_q;
	assign ys = cy_q >>> it_q;

	always_comb begin
		off = (ANG_BITS+1)'(ang_q) + (ANG_BITS+1)'(35'sd1073741824);
		if (off < 0)
			off = '0;
		if (off > (ANG_BITS+1)'(35'sd2147483648))
			off = (ANG_BITS+1)'(35'sd2147483648);
		prod = (ANG_BITS+12)'(off[31:0]) * (ANG_BITS+12)'(SECTOR_COUNT);
		if (off[31])
			prod = (ANG_BITS+12)'(32'h8000_0000) * (ANG_BITS+12)'(SECTOR_COUNT);
		if (prod[ANG_BITS+11:31] >= (ANG_BITS-19)'(SECTOR_COUNT))
			sidx = SIB'(SECTOR_COUNT - 1);
		else
			sidx = prod[31+SIB-1:31];
		cell_sec = CW'(ring_q) * CW'(SECTOR_COUNT) + CW'(sidx);
	end

	assign in_ready = (st_q == ST_IDLE);
	assign q_valid  = (st_q == ST_OUT);
	assign q_op = op_q;
	assign q_hit = hit_q;
	assign q_cell = cell_q;
	assign q_x = x_q;
	assign q_y = y_q;
	assign q_z = z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q <= op;
						ring_q <= ring;
						x_q <= px;
						y_q <= py;
						z_q <= pz;
						cx_q <= XB'(dx) <<< 12;
						cy_q <= XB'(dy) <<< 12;
						if (op == OP_INSERT) begin
							hit_q <= (32'(ring) < RING_COUNT) && !dx[DB-1];
							st_q <= ST_ROT;
							if (dy == '0) begin
								ang_q <= '0;
								it_q <= 5'(CORDIC_STEPS);
							end else if (dx == '0) begin
								ang_q <= dy[DB-1] ? -34'sd1073741824 : 34'sd1073741824;
								it_q <= 5'(CORDIC_STEPS);
							end else begin
								ang_q <= '0;
								it_q <= '0;
							end
						end else begin
							hit_q <= (32'(ring) < RING_COUNT) && (32'(sector) < SECTOR_COUNT);
							cell_q <= CW'(ring) * CW'(SECTOR_COUNT) + CW'(sector);
							st_q <= ST_OUT;
						end
					end
				end
				ST_ROT: begin
					if (it_q == 5'(CORDIC_STEPS)) begin
						cell_q <= cell_sec;
						st_q <= ST_OUT;
					end else begin
						if (!cy_q[XB-1]) begin
							cx_q <= cx_q + ys;
							cy_q <= cy_q - xs;
							ang_q <= ang_q + atan_val(it_q);
						end else begin
							cx_q <= cx_q - ys;
							cy_q <= cy_q + xs;
							ang_q <= ang_q - atan_val(it_q);
						end
						it_q <= it_q + 5'd1;
					end
				end
				ST_OUT: begin
					if (q_ready)
						st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[src/pnpb_back.sv]
// Back end: table memory, compare-and-replace, reads, clear sweep, output reg.
module pnpb_back #(
	parameter int CELLS      = 1440,
	parameter int COORD_BITS = pnpb_pkg::COORD_BITS_DEF,
	parameter int CW         = 11
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	output logic                         q_ready,
	input  logic [1:0]                   q_op,
	input  logic                         q_hit,
	input  logic [CW-1:0]                q_cell,
	input  logic signed [COORD_BITS-1:0] q_x,
	input  logic signed [COORD_BITS-1:0] q_y,
	input  logic signed [COORD_BITS-1:0] q_z,
	input  logic signed [COORD_BITS-1:0] org_x,
	input  logic signed [COORD_BITS-1:0] org_y,
	output logic                         busy,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] nx,
	output logic signed [COORD_BITS-1:0] ny,
	output logic signed [COORD_BITS-1:0] nz,
	output logic                         occ
);
	import pnpb_pkg::*;

	localparam int EW = 3 * COORD_BITS + 1;
	localparam int DB = COORD_BITS + 1;
	localparam int SQB = 2 * DB + 1;

	typedef enum logic [4:0] {
		B_IDLE  = 5'b00001,
		B_RD    = 5'b00010,
		B_MUL   = 5'b00100,
		B_CMP   = 5'b01000,
		B_CLR   = 5'b10000
	} bst_t;

	logic [EW-1:0] mem [CELLS];
	logic [EW-1:0] rd_q;
	bst_t st_q;
	logic [CW-1:0] ptr_q;
	logic [1:0] op_q;
	logic hit_q;
	logic [CW-1:0] cell_q;
	logic signed [COORD_BITS-1:0] x_q, y_q, z_q;
	logic [SQB-1:0] nsq_q, osq_q;
	logic we;
	logic [CW-1:0] wa;
	logic [EW-1:0] wd;
	logic signed [DB-1:0] ndx, ndy, odx, ody;

	assign ndx = DB'(x_q) - DB'(org_x);
	assign ndy = DB'(y_q) - DB'(org_y);
	assign odx = DB'($signed(rd_q[EW-2 -: COORD_BITS])) - DB'(org_x);
	assign ody = DB'($signed(rd_q[EW-2-COORD_BITS -: COORD_BITS])) - DB'(org_y);

	assign q_ready = (st_q == B_IDLE) && !out_valid;
	assign busy = (st_q != B_IDLE);

	always_comb begin
		we = 1'b0;
		wa = cell_q;
		wd = {1'b1, x_q, y_q, z_q};
		if (st_q == B_CLR) begin
			we = 1'b1;
			wa = ptr_q;
			wd = '0;
		end else if (st_q == B_CMP) begin
			we = !rd_q[EW-1] || (nsq_q < osq_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rd_q <= mem[q_valid && q_ready ? q_cell : cell_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_CLR;
			ptr_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				out_valid <= 1'b0;
			case (st_q)
				B_IDLE: begin
					if (q_valid && q_ready) begin
						op_q <= q_op;
						hit_q <= q_hit;
						cell_q <= q_cell;
						x_q <= q_x;
						y_q <= q_y;
						z_q <= q_z;
						if (q_op == OP_CLEAR) begin
							ptr_q <= '0;
							st_q <= B_CLR;
						end else if (q_op == OP_READ) begin
							st_q <= B_RD;
						end else if (q_op == OP_INSERT && q_hit) begin
							st_q <= B_RD;
						end
					end
				end
				B_RD: begin
					if (op_q == OP_READ) begin
						out_valid <= 1'b1;
						nx <= hit_q ? $signed(rd_q[EW-2 -: COORD_BITS]) : '0;
						ny <= hit_q ? $signed(rd_q[EW-2-COORD_BITS -: COORD_BITS]) : '0;
						nz <= hit_q ? $signed(rd_q[COORD_BITS-1:0]) : '0;
						occ <= hit_q && rd_q[EW-1];
						st_q <= B_IDLE;
					end else begin
						st_q <= B_MUL;
					end
				end
				B_MUL: begin
					nsq_q <= SQB'(ndx * ndx) + SQB'(ndy * ndy);
					osq_q <= SQB'(odx * odx) + SQB'(ody * ody);
					st_q <= B_CMP;
				end
				B_CMP: st_q <= B_IDLE;
				B_CLR: begin
					if (ptr_q == CW'(CELLS - 1))
						st_q <= B_IDLE;
					ptr_q <= ptr_q + 1'b1;
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

endmodule

[src/polar_nearest_point_binner.sv]
// Polar nearest-point binner. Each item is an insert (op 0), a read (op 1) or
// a clear (op 2). An insert takes the point relative to origin_x/origin_y,
// drops it if it lies behind the origin, finds its angle with an iterative
// CORDIC (one micro-rotation a cycle, 28 steps) and keeps it in its
// (ring, sector) cell if the cell is empty or the point is strictly closer.
// An insert holds the front end through its rotation steps (none when the
// point lies on an axis through the origin, where no rotation is needed);
// the back end then reads the cell, squares both distances, compares and
// writes. A read returns one item with the cell contents (zero and occupied
// 0 when empty or out of range) once the back end has read the cell; the
// front takes the next item once it hands the read on. While a result waits
// in the output register the back end takes nothing more. A clear and the
// pass after reset sweep all RING_COUNT*SECTOR_COUNT cells (1440 by default)
// one cell a cycle, during which no item goes to the back end. Front and
// back are split by a one-item handoff register so the front can start the
// next angle while the back updates the table. The user must write
// configuration only while the block is idle; the block does not enforce it.
module polar_nearest_point_binner #(
	parameter int RING_COUNT   = pnpb_pkg::RING_COUNT_DEF,
	parameter int SECTOR_COUNT = pnpb_pkg::SECTOR_COUNT_DEF,
	parameter int COORD_BITS   = pnpb_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [COORD_BITS-1:0]        cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   operation,
	input  logic [3:0]                   ring_index,
	input  logic [6:0]                   sector_index,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic signed [COORD_BITS-1:0] point_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] near_x,
	output logic signed [COORD_BITS-1:0] near_y,
	output logic signed [COORD_BITS-1:0] near_z,
	output logic                         occupied
);
	import pnpb_pkg::*;
	`include "assert_macros.svh"

	localparam int CELLS = RING_COUNT * SECTOR_COUNT;
	localparam int CW = $clog2(CELLS);

	logic signed [COORD_BITS-1:0] org_x_q, org_y_q;
	logic q_valid, q_ready, q_hit, busy;
	logic [1:0] q_op;
	logic [CW-1:0] q_cell;
	logic signed [COORD_BITS-1:0] q_x, q_y, q_z;

	// Origin registers; index 1 selects origin_y.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0;
			org_y_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index)
				org_y_q <= $signed(cfg_data);
			else
				org_x_q <= $signed(cfg_data);
		end
	end

	pnpb_front #(
		.RING_COUNT(RING_COUNT), .SECTOR_COUNT(SECTOR_COUNT),
		.COORD_BITS(COORD_BITS), .RB(4), .SB(7), .CW(CW)
	) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(operation), .ring(ring_index), .sector(sector_index),
		.px(point_x), .py(point_y), .pz(point_z),
		.org_x(org_x_q), .org_y(org_y_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_op(q_op), .q_hit(q_hit),
		.q_cell(q_cell), .q_x(q_x), .q_y(q_y), .q_z(q_z)
	);

	pnpb_back #(
		.CELLS(CELLS), .COORD_BITS(COORD_BITS), .CW(CW)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_op(q_op), .q_hit(q_hit),
		.q_cell(q_cell), .q_x(q_x), .q_y(q_y), .q_z(q_z),
		.org_x(org_x_q), .org_y(org_y_q), .busy(busy),
		.out_valid(out_valid), .out_ready(out_ready),
		.nx(near_x), .ny(near_y), .nz(near_z), .occ(occupied)
	);

	// A handoff from front to back never happens while the back is mid-item.
	`ASSERT_IMPL(a_no_handoff_busy, clk, arst_n, q_valid && q_ready, !busy)
	// A delivered result leaves the output register empty next cycle.
	`ASSERT_NEXT(a_out_drains, clk, arst_n, out_valid && out_ready, !out_valid)
	// A handed-off cell index always lies inside the table when it hits.
	`ASSERT_IMPL(a_cell_range, clk, arst_n, q_valid && q_hit, 32'(q_cell) < CELLS)

endmodule

[tb/sv/pnpb_scoreboard.sv]
module pnpb_scoreboard (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [17:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  operation,
	input  logic [3:0]  ring_index,
	input  logic [6:0]  sector_index,
	input  logic [17:0] point_x,
	input  logic [17:0] point_y,
	input  logic [17:0] point_z,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [17:0] near_x,
	input  logic [17:0] near_y,
	input  logic [17:0] near_z,
	input  logic        occupied,
	output int          fail_count,
	output int          pending,
	output int          reads_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import pnpb_pkg::*;

	localparam int RINGS   = RING_COUNT_DEF;
	localparam int SECTORS = SECTOR_COUNT_DEF;
	localparam int CELLS   = RINGS * SECTORS;
	localparam int CB      = COORD_BITS_DEF;

	typedef struct {
		logic signed [CB-1:0] x;
		logic signed [CB-1:0] y;
		logic signed [CB-1:0] z;
		logic                 occ;
	} cell_read_t;

	localparam longint ARC_STEP [28] = '{
		536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
		10680350, 5340245, 2670163, 1335086, 667544, 333772, 166886, 83443,
		41721, 20860, 10430, 5215, 2607, 1303, 651, 325, 162, 81, 40, 20, 10, 5
	};

	logic signed [CB-1:0] bin_x [CELLS];
	logic signed [CB-1:0] bin_y [CELLS];
	logic signed [CB-1:0] bin_z [CELLS];
	logic                 bin_occ [CELLS];
	longint               org_x, org_y;
	cell_read_t           read_q [$];

	// angle in units where pi = 2^31, CORDIC vectoring with floor shifts
	function automatic longint bearing(longint dx, longint dy);
		longint x, y, z, xs, ys;
		z = 0;
		if (dy == 0)
			return 0;
		if (dx == 0)
			return (dy > 0) ? (64'sd1 <<< 30) : -(64'sd1 <<< 30);
		x = dx * 4096;
		y = dy * 4096;
		for (int i = 0; i < 28; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ARC_STEP[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ARC_STEP[i];
			end
		end
		return z;
	endfunction

	function automatic int sector_of(longint ang);
		longint a;
		longint s;
		a = ang + (64'sd1 <<< 30);
		if (a < 0)
			a = 0;
		if (a > (64'sd1 <<< 31))
			a = 64'sd1 <<< 31;
		s = (a * SECTORS) >>> 31;
		if (s >= SECTORS)
			s = SECTORS - 1;
		return int'(s);
	endfunction

	task automatic bin_point(int ring, logic signed [CB-1:0] px, logic signed [CB-1:0] py,
			logic signed [CB-1:0] pz);
		longint dx, dy, odx, ody, r_new, r_old;
		int c;
		dx = longint'(px) - org_x;
		dy = longint'(py) - org_y;
		if (dx < 0)
			return;
		c = ring * SECTORS + sector_of(bearing(dx, dy));
		r_new = dx * dx + dy * dy;
		odx = longint'(bin_x[c]) - org_x;
		ody = longint'(bin_y[c]) - org_y;
		r_old = odx * odx + ody * ody;
		// ties keep the older point
		if (!bin_occ[c] || r_new < r_old) begin
			bin_x[c] = px;
			bin_y[c] = py;
			bin_z[c] = pz;
			bin_occ[c] = 1'b1;
		end
	endtask

	assign pending = read_q.size();

	always @(posedge clk or negedge arst_n) begin
		cell_read_t got, want;
		int c;
		if (!arst_n) begin
			for (int i = 0; i < CELLS; i++) begin
				bin_x[i] = '0;
				bin_y[i] = '0;
				bin_z[i] = '0;
				bin_occ[i] = 1'b0;
			end
			org_x = 0;
			org_y = 0;
			read_q.delete();
			fail_count = 0;
			reads_checked = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{near_x, near_y, near_z, occupied};
				if (read_q.size() == 0) begin
					$error("read result with nothing outstanding");
					fail_count++;
				end else begin
					want = read_q.pop_front();
					reads_checked++;
					if (got.x !== want.x) begin
						$error("near_x expected %0d actual %0d", want.x, got.x);
						fail_count++;
					end
					if (got.y !== want.y) begin
						$error("near_y expected %0d actual %0d", want.y, got.y);
						fail_count++;
					end
					if (got.z !== want.z) begin
						$error("near_z expected %0d actual %0d", want.z, got.z);
						fail_count++;
					end
					if (got.occ !== want.occ) begin
						$error("occupied expected %0d actual %0d", want.occ, got.occ);
						fail_count++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index)
					org_y = longint'($signed(cfg_data));
				else
					org_x = longint'($signed(cfg_data));
			end
			if (in_valid && in_ready) begin
				case (op_t'(operation))
					OP_CLEAR: begin
						for (int i = 0; i < CELLS; i++) begin
							bin_x[i] = '0;
							bin_y[i] = '0;
							bin_z[i] = '0;
							bin_occ[i] = 1'b0;
						end
					end
					OP_READ: begin
						want = '{'0, '0, '0, 1'b0};
						if (ring_index < RINGS && sector_index < SECTORS) begin
							c = ring_index * SECTORS + sector_index;
							want = '{bin_x[c], bin_y[c], bin_z[c], bin_occ[c]};
						end
						read_q.insert(read_q.size(), want);
					end
					OP_INSERT: begin
						if (ring_index < RINGS)
							bin_point(ring_index, point_x, point_y, point_z);
					end
					default: ;
				endcase
			end
		end
	end
endmodule

[tb/sv/tb_polar_nearest_point_binner.sv]
module tb_polar_nearest_point_binner;
	timeunit 1ns;
	timeprecision 1ps;
	import pnpb_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	// register indexes of the config channel
	localparam logic REG_ORIGIN_X = 1'b0;
	localparam logic REG_ORIGIN_Y = 1'b1;
	localparam logic signed [CB-1:0] CMAX = 18'sd131071;
	localparam logic signed [CB-1:0] CMIN = -18'sd131072;
	// a clear sweeps 1440 cells and a second one can wait in the front end
	localparam int DRAIN_CYCLES = 3000;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 135;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = REG_ORIGIN_X;
	logic [CB-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] operation = OP_NONE;
	logic [3:0] ring_index = '0;
	logic [6:0] sector_index = '0;
	logic signed [CB-1:0] point_x = '0;
	logic signed [CB-1:0] point_y = '0;
	logic signed [CB-1:0] point_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CB-1:0] near_x, near_y, near_z;
	logic occupied;

	int fail_count, pending, reads_checked;
	int idle_pct = 0;   // sender gap chance, percent
	int stall_pct = 0;  // receiver stall chance, percent
	int items_sent = 0;
	int cycle_count = 0;
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;

	always #2 clk = ~clk;

	polar_nearest_point_binner u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.ring_index(ring_index), .sector_index(sector_index),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.near_x(near_x), .near_y(near_y), .near_z(near_z), .occupied(occupied)
	);

	pnpb_scoreboard u_scoreboard (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .operation(operation),
		.ring_index(ring_index), .sector_index(sector_index),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.near_x(near_x), .near_y(near_y), .near_z(near_z), .occupied(occupied),
		.fail_count(fail_count), .pending(pending), .reads_checked(reads_checked)
	);

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off to back the block up
	always @(posedge clk) begin
		if (hold_go && !hold_done) begin
			hold_left <= 600;
			hold_done <= 1'b1;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// one item on the input channel; valid stays up when no gap follows
	task automatic send_item(op_t op, int ring, int sec, logic signed [CB-1:0] px,
			logic signed [CB-1:0] py, logic signed [CB-1:0] pz);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		ring_index <= ring[3:0];
		sector_index <= sec[6:0];
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic cfg_write(logic idx, logic signed [CB-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until all reads are back, then for the slowest silent work to finish
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// coordinates: often near zero so cells collide, with extremes and random values mixed in
	function automatic logic signed [CB-1:0] pick_coord();
		case ($urandom_range(9))
			0: return CMAX;
			1: return CMIN;
			2: return '0;
			3, 4, 5: return CB'($signed($urandom_range(4000)) - 2000);
			default: return CB'($urandom);
		endcase
	endfunction

	initial begin
		logic signed [CB-1:0] ox, oy;
		int r;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// block runs a clearing sweep after reset
		repeat (DRAIN_CYCLES) @(posedge clk);

		// directed: default origin, edges of the half-plane and the table
		send_item(OP_INSERT, 0, 0, '0, '0, 18'sd7);           // point at origin
		send_item(OP_INSERT, 1, 0, CMAX, '0, CMIN);           // straight ahead
		send_item(OP_INSERT, 2, 0, '0, CMAX, CMAX);           // edge on the +y axis, last sector
		send_item(OP_INSERT, 3, 0, '0, CMIN, 18'sd1);         // edge on the -y axis
		send_item(OP_INSERT, 4, 0, -18'sd1, 18'sd50, 18'sd1); // behind, dropped
		send_item(OP_INSERT, 5, 0, CMAX, CMAX, 18'sd3);
		send_item(OP_INSERT, 6, 0, CMAX, CMIN, 18'sd4);
		send_item(OP_INSERT, 7, 0, 18'sd100, 18'sd100, 18'sd5);
		send_item(OP_INSERT, 7, 0, 18'sd100, 18'sd100, 18'sd6); // tie keeps older
		send_item(OP_INSERT, 8, 0, 18'sd500, 18'sd5, 18'sd8);
		send_item(OP_INSERT, 8, 0, 18'sd400, 18'sd4, 18'sd9);   // closer replaces
		send_item(OP_INSERT, 15, 0, 18'sd300, '0, 18'sd2);
		send_item(OP_NONE, 0, 0, CMAX, CMAX, CMAX);             // unused code
		send_item(OP_READ, 0, 45, '0, '0, '0);
		send_item(OP_READ, 1, 45, '0, '0, '0);
		send_item(OP_READ, 2, 89, '0, '0, '0);
		send_item(OP_READ, 3, 0, '0, '0, '0);
		send_item(OP_READ, 7, 67, '0, '0, '0);
		send_item(OP_READ, 8, 45, '0, '0, '0);
		send_item(OP_READ, 15, 45, '0, '0, '0);
		send_item(OP_READ, 5, 90, '0, '0, '0);                  // sector out of range
		send_item(OP_READ, 15, 127, '0, '0, '0);
		send_item(OP_CLEAR, 0, 0, '0, '0, '0);
		send_item(OP_READ, 1, 45, '0, '0, '0);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin ox = '0; oy = '0; end
				1: begin ox = CMAX; oy = CMIN; end
				2: begin ox = CMIN; oy = CMAX; end
				3: begin ox = CMIN; oy = CMIN; end
				default: begin
					ox = CB'($signed($urandom_range(2000)) - 1000);
					oy = CB'($urandom);
				end
			endcase
			cfg_write(REG_ORIGIN_X, ox);
			cfg_write(REG_ORIGIN_Y, oy);
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 48; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 48; end
				default: begin idle_pct = 15; stall_pct = 15; end
			endcase
			if (p == 1)
				hold_go = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(99);
				if (p == 1 && k < 40) begin
					// stream reads into the hold-off so the block backs up
					send_item(OP_READ, $urandom_range(15), $urandom_range(89),
						pick_coord(), pick_coord(), pick_coord());
				end else if (r < 55) begin
					send_item(OP_INSERT,
						($urandom_range(1) ? $urandom_range(3) : $urandom_range(15)), 0,
						pick_coord(), pick_coord(), pick_coord());
				end else if (r < 95) begin
					send_item(OP_READ,
						($urandom_range(1) ? $urandom_range(3) : $urandom_range(15)),
						($urandom_range(19) == 0 ? $urandom_range(127) : $urandom_range(89)),
						pick_coord(), pick_coord(), pick_coord());
				end else if (r < 97) begin
					send_item(OP_CLEAR, $urandom_range(15), $urandom_range(127),
						pick_coord(), pick_coord(), pick_coord());
				end else begin
					send_item(OP_NONE, $urandom_range(15), $urandom_range(127),
						pick_coord(), pick_coord(), pick_coord());
				end
			end
			drain();
		end

		$display("Covered %0d items over %0d origin settings, %0d reads checked",
			items_sent, PHASES, reads_checked);
		$display("Idle modes: none, sender gaps, receiver stalls, both; one long hold-off");
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
